// File: rtl/bsfd_pkg.sv
`timescale 1ns / 1ps
package bsfd_pkg;

  // Frame layout: a fixed header, with the length byte second to last in it.
  localparam int HEADER_BYTES = 9;
  localparam logic [5:0] LENGTH_POS   = 6'(HEADER_BYTES - 2);
  localparam logic [5:0] LAST_HDR_POS = 6'(HEADER_BYTES - 1);
  localparam logic [7:0] MIN_LENGTH   = 8'(HEADER_BYTES);
  localparam logic [6:0] INDEX_LIMIT  = 7'd64;

  localparam logic [7:0] CHECK_INIT = 8'hFF;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] CFG_INVERT_BITS  = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

  localparam logic [23:0] SYNC_PATTERN_RST = 24'h5555F0;
  localparam logic        INVERT_BITS_RST  = 1'b1;
  localparam logic [6:0]  MAX_LENGTH_RST   = 7'd54;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       frame_end;
    logic       frame_abort;
    logic       checksum_ok;
  } bsfd_result_t;

endpackage

// File: rtl/bit_stream_frame_deframer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_sample_bit
// out_      output     out_valid/out_stall  out_data_byte, out_byte_index, out_frame_end,
//                                           out_frame_abort, out_checksum_ok
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample bit is taken every cycle while in_stall is low; a byte result passes
// the input register, then the result register, after the bit that completes it.
// Synchronous active-low reset returns to sync hunt with config registers at defaults.
// A stalled output only holds up a bit that completes a byte; other bits flow on
// as long as the input register drains.
module bit_stream_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_sample_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_frame_end,
  output logic        out_frame_abort,
  output logic        out_checksum_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import bsfd_pkg::*;

  logic [23:0]  sync_pattern_r;
  logic         invert_bits_r;
  logic [6:0]   max_length_r;

  logic         in_vld_r, in_vld_nxt;
  logic         in_bit_r;
  logic         in_accept;

  logic         bit_taken;
  logic         res_vld;
  logic         res_ready;
  bsfd_result_t res;
  bsfd_result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= SYNC_PATTERN_RST;
      invert_bits_r  <= INVERT_BITS_RST;
      max_length_r   <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_PATTERN: sync_pattern_r <= cfg_data;
        CFG_INVERT_BITS:  invert_bits_r  <= cfg_data[0];
        CFG_MAX_LENGTH:   max_length_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = in_vld_r && !bit_taken;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (bit_taken) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_bit_r <= in_sample_bit;
    end
  end

  bsfd_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .bit_vld      (in_vld_r),
    .bit_raw      (in_bit_r),
    .sync_pattern (sync_pattern_r),
    .invert_bits  (invert_bits_r),
    .max_length   (max_length_r),
    .res_ready    (res_ready),
    .bit_taken    (bit_taken),
    .res_vld      (res_vld),
    .res          (res)
  );

  bsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_data_byte   = out_res.data_byte;
  assign out_byte_index  = out_res.byte_index;
  assign out_frame_end   = out_res.frame_end;
  assign out_frame_abort = out_res.frame_abort;
  assign out_checksum_ok = out_res.checksum_ok;

endmodule

// File: rtl/bsfd_step.sv
`timescale 1ns / 1ps
module bsfd_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    bit_vld,
  input  logic                    bit_raw,
  input  logic [23:0]             sync_pattern,
  input  logic                    invert_bits,
  input  logic [6:0]              max_length,
  input  logic                    res_ready,
  output logic                    bit_taken,
  output logic                    res_vld,
  output bsfd_pkg::bsfd_result_t  res
);
  import bsfd_pkg::*;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [23:0] window_r, window_nxt;
  logic [2:0]  bib_r, bib_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [7:0]  flen_r, flen_nxt;
  logic [7:0]  check_r, check_nxt;

  logic        bit_in;
  logic [23:0] window_shift;
  logic [7:0]  byte_w;
  logic        byte_done;
  logic [6:0]  limit;
  logic        abort_w;
  logic        end_w;

  assign bit_in       = bit_raw ^ invert_bits;
  assign window_shift = {window_r[22:0], bit_in};
  assign byte_w       = window_shift[7:0];
  assign byte_done    = (mode_r == MODE_FRAME) && (bib_r == 3'd7);

  // Lengths past the widest index the output can carry are clipped.
  assign limit   = (max_length > INDEX_LIMIT) ? INDEX_LIMIT : max_length;
  assign abort_w = byte_done && (count_r == LAST_HDR_POS) &&
                   ((flen_r < MIN_LENGTH) || (flen_r > {1'b0, limit}));
  assign end_w   = byte_done && !abort_w && (count_r >= LAST_HDR_POS) &&
                   (({2'b00, count_r} + 8'd1) == flen_r);

  // A bit that completes a byte waits for room downstream; others never do.
  assign res_vld   = bit_vld && byte_done;
  assign bit_taken = bit_vld && (!byte_done || res_ready);

  always_comb begin
    res.data_byte   = byte_w;
    res.byte_index  = count_r;
    res.frame_end   = end_w;
    res.frame_abort = abort_w;
    res.checksum_ok = end_w && (byte_w == check_r);
  end

  always_comb begin
    mode_nxt   = mode_r;
    window_nxt = window_r;
    bib_nxt    = bib_r;
    count_nxt  = count_r;
    flen_nxt   = flen_r;
    check_nxt  = check_r;
    if (bit_taken) begin
      window_nxt = window_shift;
      case (mode_r)
        MODE_FRAME: begin
          bib_nxt = bib_r + 3'd1;
          if (byte_done) begin
            if (count_r == LENGTH_POS) begin
              flen_nxt = byte_w;
            end
            if (abort_w || end_w) begin
              mode_nxt  = MODE_HUNT;
              bib_nxt   = 3'd0;
              count_nxt = 6'd0;
              check_nxt = CHECK_INIT;
            end else begin
              check_nxt = check_r ^ byte_w;
              count_nxt = count_r + 6'd1;
            end
          end
        end
        default: begin
          if (window_shift == sync_pattern) begin
            mode_nxt  = MODE_FRAME;
            bib_nxt   = 3'd0;
            count_nxt = 6'd0;
            check_nxt = CHECK_INIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_HUNT;
      window_r <= '0;
      bib_r    <= '0;
      count_r  <= '0;
      flen_r   <= '0;
      check_r  <= CHECK_INIT;
    end else begin
      mode_r   <= mode_nxt;
      window_r <= window_nxt;
      bib_r    <= bib_nxt;
      count_r  <= count_nxt;
      flen_r   <= flen_nxt;
      check_r  <= check_nxt;
    end
  end

  a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_taken && res_vld && (res.frame_end || res.frame_abort)) |=> (mode_r == MODE_HUNT))
    else $error("frame did not return to sync hunt after its last byte");

  a_end_abort_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !(res.frame_end && res.frame_abort))
    else $error("result flagged as both frame end and abort");

  a_sync_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_taken && mode_r != MODE_FRAME && mode_nxt == MODE_FRAME) |=>
      (bib_r == 3'd0 && count_r == 6'd0 && check_r == CHECK_INIT))
    else $error("frame started with stale byte state");

endmodule

// File: rtl/bsfd_out_reg.sv
`timescale 1ns / 1ps
module bsfd_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_vld,
  input  bsfd_pkg::bsfd_result_t  res,
  output logic                    res_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bsfd_pkg::bsfd_result_t  out_res
);
  import bsfd_pkg::*;

  logic         vld_r, vld_nxt;
  bsfd_result_t res_r;

  // The register can reload in the same cycle its request leaves.
  assign res_ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_ready) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
